@@ rtl/pf_alu_pkg.sv @@
// ----------------------------------------------------------------------------
// pf_alu_pkg
// Operation and status codes shared by the prime field arithmetic unit.
// ----------------------------------------------------------------------------
package pf_alu_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_SUB = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    localparam int unsigned FUNC_BITS   = 2;
    localparam int unsigned STATUS_BITS = 2;

endpackage

@@ rtl/prime_field_alu.sv @@
// ----------------------------------------------------------------------------
// prime_field_alu
// Add, multiply, subtract and divide modulo a configurable modulus p.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Add and subtract are computed
// on acceptance; multiply runs a bit-serial shift-and-add over the operand_b
// bits; divide walks the candidates i = 1 .. p-1 with one modular addition
// per cycle. The sequencer holds one transaction at a time; the output
// register lets the next one be accepted while a result waits. An operand
// not below p gives status 1 and result 0; divide by zero gives status 2.
// When p is not prime divide returns the largest matching i, or 0 if there
// is none. Write the modulus only while idle.
module prime_field_alu #(
    parameter int unsigned VALUE_BITS = 10
) (
    input  logic aclk,
    input  logic aresetn,
    // modulus register
    input  logic                    cfg_we,
    input  logic [VALUE_BITS-1:0]   cfg_wdata,
    // input stream: [func | operand_a | operand_b | zero pad], low bits first
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [((pf_alu_pkg::FUNC_BITS + 2*VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // output stream: [result | status | zero pad], low bits first
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((VALUE_BITS + pf_alu_pkg::STATUS_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
    import pf_alu_pkg::*;

    localparam int unsigned W       = VALUE_BITS;
    localparam int unsigned OUT_BITS = ((W + STATUS_BITS + 7) / 8) * 8;
    localparam int unsigned CW      = $clog2(W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    function automatic logic [W-1:0] mod_add(input logic [W-1:0] x,
                                              input logic [W-1:0] y,
                                              input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [W-1:0]       mod_reg;
    logic [W-1:0]       op_a_reg, op_a_next;
    logic [W-1:0]       op_b_reg, op_b_next;   // divisor, or multiplier shift reg
    logic [W-1:0]       acc_reg, acc_next;
    logic [W-1:0]       idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [W-1:0]       res_reg, res_next;
    status_t            st_reg, st_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0] m_data_reg, m_data_next;

    logic [FUNC_BITS-1:0] in_func;
    logic [W-1:0]       in_a, in_b;
    logic               s_fire;
    logic               out_free;
    logic [W:0]         sub_wide;
    logic [W-1:0]       mul_dbl;

    assign in_func = s_tdata[FUNC_BITS-1:0];
    assign in_a    = s_tdata[FUNC_BITS +: W];
    assign in_b    = s_tdata[FUNC_BITS + W +: W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign sub_wide = (in_a >= in_b) ? ({1'b0, in_a} - {1'b0, in_b})
                                     : ({1'b0, in_a} + {1'b0, mod_reg} - {1'b0, in_b});
    assign mul_dbl  = mod_add(acc_reg, acc_reg, mod_reg);

    always_comb begin
        state_next   = state_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_a_next  = in_a;
                    op_b_next  = in_b;
                    res_next   = '0;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                    if (in_a >= mod_reg || in_b >= mod_reg) begin
                        st_next = ST_RANGE;
                    end else begin
                        case (func_t'(in_func))
                            FUNC_ADD: res_next = mod_add(in_a, in_b, mod_reg);
                            FUNC_SUB: res_next = sub_wide[W-1:0];
                            FUNC_MUL: begin
                                acc_next   = '0;
                                cnt_next   = CW'(W);
                                state_next = S_MUL;
                            end
                            FUNC_DIV: begin
                                if (in_b == '0) begin
                                    st_next = ST_DIV_ZERO;
                                end else begin
                                    acc_next   = in_b;
                                    idx_next   = W'(1);
                                    state_next = S_DIV;
                                end
                            end
                            default: st_next = ST_OK;
                        endcase
                    end
                end
            end
            S_MUL: begin
                // MSB first: acc = 2*acc + bit*a, reduced each step
                acc_next  = mod_add(mul_dbl, op_b_reg[W-1] ? op_a_reg : '0, mod_reg);
                op_b_next = {op_b_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    res_next   = acc_next;
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                // acc tracks b*idx mod p; last hit is the largest quotient
                if (acc_reg == op_a_reg) begin
                    res_next = idx_reg;
                end
                acc_next = mod_add(acc_reg, op_b_reg, mod_reg);
                idx_next = idx_reg + W'(1);
                if (idx_reg == mod_reg - W'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_BITS'({st_reg, res_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mod_reg     <= W'(2);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mod_reg <= cfg_wdata;
            end
        end
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
    end

    // candidate index and running product stay reduced during the search
    a_div_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (idx_reg < mod_reg && acc_reg < mod_reg))
        else $error("divide search left the field");

    a_mul_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (acc_reg < mod_reg && cnt_reg != '0))
        else $error("multiply accumulator or count out of range");

    a_err_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[W +: STATUS_BITS] != ST_OK) |-> (m_data_reg[W-1:0] == '0))
        else $error("nonzero result with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[W +: STATUS_BITS] == ST_OK
                         || m_data_reg[W +: STATUS_BITS] == ST_RANGE
                         || m_data_reg[W +: STATUS_BITS] == ST_DIV_ZERO))
        else $error("undefined status code");

    a_load_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE && state_reg == S_IDLE))
        else $error("result issued outside completion");

endmodule

@@ test/prime_field_alu_checker.sv @@
// ----------------------------------------------------------------------------
// prime_field_alu_checker
// Watches the modulus writes and both streams of the prime field unit. It
// computes the expected result and status of every accepted operation and
// compares them, in order, with the results the unit hands out.
// ----------------------------------------------------------------------------
module prime_field_alu_checker #(
    parameter int unsigned VALUE_BITS = 10,
    parameter int unsigned S_WIDTH    = 24,
    parameter int unsigned M_WIDTH    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [VALUE_BITS-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_WIDTH-1:0]    s_tdata,     // func, operand_a, operand_b
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_WIDTH-1:0]    m_tdata,     // result, status
    output int unsigned           outstanding,
    output int unsigned           mismatches,
    output int unsigned           checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import pf_alu_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result;
        status_t               status;
    } field_out_t;

    field_out_t            results_due[$];
    logic [VALUE_BITS-1:0] modulus_q;

    initial begin
        outstanding = 0;
        mismatches  = 0;
        checked     = 0;
    end

    function automatic field_out_t field_op_result(func_t op, logic [VALUE_BITS-1:0] a,
                                                   logic [VALUE_BITS-1:0] b,
                                                   logic [VALUE_BITS-1:0] p);
        field_out_t        r;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   m;
        longint unsigned   i;
        x = a;
        y = b;
        m = p;
        r.result = '0;
        r.status = ST_OK;
        // range check wins over every other case, divide by zero included
        if (x >= m || y >= m) begin
            r.status = ST_RANGE;
        end else begin
            case (op)
                FUNC_ADD: r.result = VALUE_BITS'((x + y) % m);
                FUNC_MUL: r.result = VALUE_BITS'((x * y) % m);
                FUNC_SUB: r.result = VALUE_BITS'((x >= y) ? (x - y) : (x + m - y));
                FUNC_DIV: begin
                    if (y == 0) begin
                        r.status = ST_DIV_ZERO;
                    end else begin
                        // largest quotient wins when p is composite; none gives 0
                        for (i = m - 1; i >= 1; i--) begin
                            if ((y * i) % m == x) begin
                                r.result = VALUE_BITS'(i);
                                break;
                            end
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatches < 40)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        field_out_t want;
        field_out_t got;
        if (!aresetn) begin
            modulus_q <= VALUE_BITS'(2);
            results_due.delete();
        end else begin
            if (cfg_we)
                modulus_q <= cfg_wdata;
            if (s_tvalid && s_tready)
                results_due.push_back(field_op_result(
                    func_t'(s_tdata[FUNC_BITS-1:0]),
                    s_tdata[FUNC_BITS +: VALUE_BITS],
                    s_tdata[FUNC_BITS + VALUE_BITS +: VALUE_BITS],
                    modulus_q));
            if (m_tvalid && m_tready) begin
                got.result = m_tdata[VALUE_BITS-1:0];
                got.status = status_t'(m_tdata[VALUE_BITS +: STATUS_BITS]);
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result transaction", 0, got.result);
                end else begin
                    want = results_due.pop_front();
                    if (got.result !== want.result)
                        report_mismatch("result", want.result, got.result);
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    checked++;
                end
            end
        end
        outstanding <= results_due.size();
    end

endmodule

@@ test/prime_field_alu_test.sv @@
// ----------------------------------------------------------------------------
// prime_field_alu_test
// Drives the prime field unit with directed corner cases and random
// add, multiply, subtract and divide transactions over a range of prime and
// composite moduli, with random stalls on both streams. A checker module
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module prime_field_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pf_alu_pkg::*;

    localparam int unsigned VB      = 10;
    localparam int unsigned S_WIDTH = ((FUNC_BITS + 2 * VB + 7) / 8) * 8;
    localparam int unsigned M_WIDTH = ((VB + STATUS_BITS + 7) / 8) * 8;
    localparam int unsigned VAL_MAX = (1 << VB) - 1;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [VB-1:0]      cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [S_WIDTH-1:0] s_tdata   = '0;  // func, operand_a, operand_b, pad
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [M_WIDTH-1:0] m_tdata;         // result, status, pad

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned send_idle_pct  = 10;
    int unsigned recv_stall_pct = 55;
    int unsigned items_sent     = 0;
    int unsigned moduli_used    = 1;     // reset value counts as one

    always #1 aclk = ~aclk;

    prime_field_alu #(.VALUE_BITS(VB)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    prime_field_alu_checker #(
        .VALUE_BITS (VB),
        .S_WIDTH    (S_WIDTH),
        .M_WIDTH    (M_WIDTH)
    ) field_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches),
        .checked     (checked)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // slow receiver first, then slow sender, then both at full rate
    task automatic issue_op(func_t op, logic [VB-1:0] a, logic [VB-1:0] b);
        if (items_sent < 167) begin
            send_idle_pct  = 10;
            recv_stall_pct = 55;
        end else if (items_sent < 334) begin
            send_idle_pct  = 55;
            recv_stall_pct = 10;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(S_WIDTH - FUNC_BITS - 2 * VB){1'b0}}, b, a, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // drain every pending transaction before touching the modulus
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_modulus(logic [VB-1:0] p);
        drain();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        moduli_used++;
    endtask

    // edges and out-of-range values show up far more often than uniform
    function automatic logic [VB-1:0] pick_operand(int unsigned p);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return VB'(p - 1);
        if (roll < 90)
            return VB'($urandom_range(p - 1, 0));
        return VB'($urandom_range(VAL_MAX, p));
    endfunction

    task automatic random_phase(int unsigned p, int unsigned count);
        write_modulus(VB'(p));
        repeat (count)
            issue_op(func_t'($urandom_range(3)), pick_operand(p), pick_operand(p));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset modulus of 2
        issue_op(FUNC_ADD, 1, 1);
        issue_op(FUNC_DIV, 1, 1);
        issue_op(FUNC_MUL, 2, 1);

        write_modulus(7);
        issue_op(FUNC_ADD, 6, 6);
        issue_op(FUNC_MUL, 6, 6);
        issue_op(FUNC_SUB, 0, 6);
        issue_op(FUNC_SUB, 5, 2);
        issue_op(FUNC_DIV, 3, 5);
        issue_op(FUNC_DIV, 0, 4);
        issue_op(FUNC_DIV, 4, 0);
        issue_op(FUNC_DIV, 7, 0);          // range error beats divide by zero
        issue_op(FUNC_ADD, 1023, 0);
        issue_op(FUNC_SUB, 0, 1023);
        issue_op(FUNC_DIV, 1023, 1023);

        // composite modulus: several quotients, or none
        write_modulus(12);
        issue_op(FUNC_DIV, 4, 2);
        issue_op(FUNC_DIV, 3, 2);
        issue_op(FUNC_DIV, 0, 6);
        issue_op(FUNC_MUL, 11, 11);

        write_modulus(1023);
        issue_op(FUNC_ADD, 1022, 1022);
        issue_op(FUNC_MUL, 1022, 1022);
        issue_op(FUNC_SUB, 0, 1022);
        issue_op(FUNC_DIV, 1, 1022);
        issue_op(FUNC_DIV, 1022, 1023);

        random_phase(1023, 60);
        random_phase(2, 60);
        random_phase(1021, 60);
        random_phase(3, 60);
        random_phase(12, 60);
        random_phase($urandom_range(1023, 2), 60);
        random_phase($urandom_range(40, 2), 60);
        random_phase(251, 60);

        drain();
        repeat (20) @(posedge aclk);

        $display("Sent %0d transactions over %0d modulus settings (prime and composite)",
                 items_sent, moduli_used);
        $display("Compared %0d results, %0d mismatches", checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still pending", outstanding);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pf_alu_pkg.sv
rtl/prime_field_alu.sv
test/prime_field_alu_checker.sv
test/prime_field_alu_test.sv
